// ===== design/ps2mf_pkg.sv =====
// Package for the PS/2 mouse packet framer: sizes, operation codes and the
// structs passed between the front end, the operation queue and the back end.
// No dependencies.
package ps2mf_pkg;

    // Byte FIFO sizing
    localparam int FIFO_DEPTH = 256;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    // Operation queue sizing
    localparam int OPQ_DEPTH = 4;
    localparam int OPQ_AW    = $clog2(OPQ_DEPTH);
    localparam int OPQ_CW    = OPQ_AW + 1;

    // Framing constants
    localparam logic [7:0] FIRST_BYTE_MARK = 8'h08;

    // Byte position within a packet being gathered
    localparam logic [1:0] GATHER_NONE = 2'd0;
    localparam logic [1:0] GATHER_ONE  = 2'd1;
    localparam logic [1:0] GATHER_TWO  = 2'd2;

    // Operation classes handed from front to back
    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,   // received byte that completes nothing
        OP_PKT  = 2'd1,   // third byte arrived: push three bytes
        OP_READ = 2'd2,   // host read with minor number zero
        OP_NULL = 2'd3    // host read with nonzero minor number
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_op_item;

    // Byte FIFO memory access
    typedef struct packed {
        logic               we;
        logic [FIFO_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic               re;
        logic [FIFO_AW-1:0] raddr;
    } t_ram_req;

endpackage

// ===== design/ps2mf_if.sv =====
// Valid/ready channel interfaces for the framer's input items and results.
// No dependencies.
interface ps2mf_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] rx_byte;
    logic [7:0] minor_number;

    modport source (output valid, output cmd, output rx_byte, output minor_number,
                    input ready);
    modport sink   (input valid, input cmd, input rx_byte, input minor_number,
                    output ready);
endinterface

interface ps2mf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       data_available;
    logic       packet_complete;

    modport source (output valid, output read_data, output data_available,
                    output packet_complete, input ready);
    modport sink   (input valid, input read_data, input data_available,
                    input packet_complete, output ready);
endinterface

// ===== design/ps2_mouse_packet_framer_fifo.sv =====
// Channel   Dir  Fields                                          Transfer when
// i_in      in   cmd, rx_byte, minor_number                      valid && ready
// o_out     out  read_data, data_available, packet_complete      valid && ready
//
// An item that completes a packet occupies the back end in S_IDLE, S_WR1 and
// S_WR2, set by the single write port of the byte FIFO memory (one byte per
// cycle, S_WR2 waiting on the output register). Popping reads add S_RD for
// the registered memory read; other items, empty or refused reads too, end in S_IDLE.
// Reset is synchronous and active low; the FIFO memory needs no clearing.
// A four-entry operation queue lets input transfers continue while the back
// end works or while a result waits in the output register.
//
// Top level of the PS/2 mouse packet framer with byte FIFO.
// Depends on ps2mf_pkg, ps2mf_if, ps2mf_ram, ps2mf_front, ps2mf_queue, ps2mf_back.
module ps2_mouse_packet_framer_fifo (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ps2mf_in_if.sink     i_in,
    ps2mf_out_if.source  o_out
);

    logic                 q_ready;
    logic                 q_push;
    ps2mf_pkg::t_op_item  q_in_item;
    logic                 q_valid;
    ps2mf_pkg::t_op_item  q_out_item;
    logic                 q_pop;
    ps2mf_pkg::t_ram_req  ram_req;
    logic [7:0]           ram_rdata;

    ps2mf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (q_push),
        .o_item    (q_in_item)
    );

    ps2mf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_out_item),
        .i_pop   (q_pop)
    );

    ps2mf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_out_item),
        .o_q_pop     (q_pop),
        .o_ram       (ram_req),
        .i_ram_rdata (ram_rdata),
        .o_out       (o_out)
    );

    ps2mf_ram #(
        .WIDTH (8),
        .DEPTH (ps2mf_pkg::FIFO_DEPTH)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

endmodule

// ===== design/ps2mf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ps2mf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/ps2mf_front.sv =====
// Front end: accepts input transfers, frames mouse bytes into three-byte
// packets and classifies each item. Depends on ps2mf_pkg and ps2mf_in_if.
module ps2mf_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ps2mf_in_if.sink             i_in,
    input  logic                 i_q_ready,
    output logic                 o_push,
    output ps2mf_pkg::t_op_item  o_item
);

    logic [1:0] r_gathered, n_gathered;
    logic [7:0] r_b0, n_b0;
    logic [7:0] r_b1, n_b1;
    logic       accept;

    assign i_in.ready = i_q_ready;
    assign accept     = i_in.valid && i_q_ready;
    assign o_push     = accept;

    // Framing and classification
    always_comb begin
        n_gathered = r_gathered;
        n_b0       = r_b0;
        n_b1       = r_b1;
        o_item.op  = ps2mf_pkg::OP_BYTE;
        o_item.b0  = r_b0;
        o_item.b1  = r_b1;
        o_item.b2  = i_in.rx_byte;
        if (i_in.cmd) begin
            o_item.op = (i_in.minor_number == 8'd0) ? ps2mf_pkg::OP_READ
                                                    : ps2mf_pkg::OP_NULL;
        end else begin
            case (r_gathered)
                ps2mf_pkg::GATHER_NONE: begin
                    // flags byte must carry the mark, else resync by dropping it
                    if ((i_in.rx_byte & ps2mf_pkg::FIRST_BYTE_MARK) != 8'd0) begin
                        n_b0       = i_in.rx_byte;
                        n_gathered = ps2mf_pkg::GATHER_ONE;
                    end
                end
                ps2mf_pkg::GATHER_ONE: begin
                    n_b1       = i_in.rx_byte;
                    n_gathered = ps2mf_pkg::GATHER_TWO;
                end
                default: begin
                    o_item.op  = ps2mf_pkg::OP_PKT;
                    n_gathered = ps2mf_pkg::GATHER_NONE;
                end
            endcase
        end
    end

    // Framer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gathered <= ps2mf_pkg::GATHER_NONE;
        end else if (accept) begin
            r_gathered <= n_gathered;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b0 <= n_b0;
            r_b1 <= n_b1;
        end
    end

endmodule

// ===== design/ps2mf_queue.sv =====
// Short operation queue between front and back end.
// Depends on ps2mf_pkg.
module ps2mf_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ps2mf_pkg::t_op_item  i_item,
    output logic                 o_ready,
    output logic                 o_valid,
    output ps2mf_pkg::t_op_item  o_item,
    input  logic                 i_pop
);

    ps2mf_pkg::t_op_item              r_mem [ps2mf_pkg::OPQ_DEPTH];
    logic [ps2mf_pkg::OPQ_AW-1:0]     r_wr, r_rd;
    logic [ps2mf_pkg::OPQ_CW-1:0]     r_cnt;
    logic                             do_push, do_pop;

    assign o_ready = (r_cnt != ps2mf_pkg::OPQ_CW'(ps2mf_pkg::OPQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == ps2mf_pkg::OPQ_AW'(ps2mf_pkg::OPQ_DEPTH - 1))
                        ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == ps2mf_pkg::OPQ_AW'(ps2mf_pkg::OPQ_DEPTH - 1))
                        ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== design/ps2mf_back.sv =====
// Back end: runs queued operations against the byte FIFO memory and holds
// each result in an output register. Depends on ps2mf_pkg and ps2mf_out_if.
module ps2mf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  ps2mf_pkg::t_op_item  i_q_item,
    output logic                 o_q_pop,
    output ps2mf_pkg::t_ram_req  o_ram,
    input  logic [7:0]           i_ram_rdata,
    ps2mf_out_if.source          o_out
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_WR1  = 4'b0100,
        S_WR2  = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    logic [ps2mf_pkg::FIFO_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [ps2mf_pkg::FIFO_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [ps2mf_pkg::FIFO_CW-1:0]   r_count, n_count;
    logic [7:0]                      r_b1, n_b1;
    logic [7:0]                      r_b2, n_b2;
    logic                            r_out_valid, n_out_valid;
    logic [7:0]                      r_rd_data, n_rd_data;
    logic                            r_avail, n_avail;
    logic                            r_done, n_done;
    logic                            out_free;
    logic                            push_en;
    logic [7:0]                      push_byte;
    logic                            fifo_full;

    localparam logic [ps2mf_pkg::FIFO_AW-1:0] PTR_LAST =
        ps2mf_pkg::FIFO_AW'(ps2mf_pkg::FIFO_DEPTH - 1);

    assign out_free  = !r_out_valid || o_out.ready;
    assign fifo_full = (r_count == ps2mf_pkg::FIFO_CW'(ps2mf_pkg::FIFO_DEPTH));

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_rd_ptr    = r_rd_ptr;
        n_b1        = r_b1;
        n_b2        = r_b2;
        n_out_valid = r_out_valid && !o_out.ready;
        n_rd_data   = r_rd_data;
        n_avail     = r_avail;
        n_done      = r_done;
        o_q_pop     = 1'b0;
        push_en     = 1'b0;
        push_byte   = r_b1;
        o_ram.re    = 1'b0;
        o_ram.raddr = r_rd_ptr;
        n_count     = r_count;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_item.op)
                        ps2mf_pkg::OP_PKT: begin
                            // first byte now, the other two in following cycles
                            o_q_pop   = 1'b1;
                            push_en   = 1'b1;
                            push_byte = i_q_item.b0;
                            n_b1      = i_q_item.b1;
                            n_b2      = i_q_item.b2;
                            n_state   = S_WR1;
                        end
                        ps2mf_pkg::OP_READ: begin
                            if (r_count != '0) begin
                                o_q_pop  = 1'b1;
                                o_ram.re = 1'b1;
                                n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
                                n_count  = r_count - 1'b1;
                                n_state  = S_RD;
                            end else if (out_free) begin
                                o_q_pop     = 1'b1;
                                n_out_valid = 1'b1;
                                n_rd_data   = 8'd0;
                                n_avail     = 1'b0;
                                n_done      = 1'b0;
                            end
                        end
                        default: begin
                            // no FIFO activity, report status only
                            if (out_free) begin
                                o_q_pop     = 1'b1;
                                n_out_valid = 1'b1;
                                n_rd_data   = 8'd0;
                                n_avail     = (r_count != '0);
                                n_done      = 1'b0;
                            end
                        end
                    endcase
                end
            end
            S_WR1: begin
                push_en   = 1'b1;
                push_byte = r_b1;
                n_state   = S_WR2;
            end
            S_WR2: begin
                if (out_free) begin
                    push_en     = 1'b1;
                    push_byte   = r_b2;
                    n_out_valid = 1'b1;
                    n_rd_data   = 8'd0;
                    n_done      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_RD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_rd_data   = i_ram_rdata;
                    n_avail     = (r_count != '0);
                    n_done      = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Byte push, dropped when the FIFO is full
        o_ram.we    = push_en && !fifo_full;
        o_ram.waddr = r_wr_ptr;
        o_ram.wdata = push_byte;
        n_wr_ptr    = r_wr_ptr;
        if (o_ram.we) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            n_count  = r_count + 1'b1;
        end
        if (r_state == S_WR2 && out_free) begin
            n_avail = (n_count != '0);
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_b1      <= n_b1;
        r_b2      <= n_b2;
        r_rd_data <= n_rd_data;
        r_avail   <= n_avail;
        r_done    <= n_done;
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.read_data       = r_rd_data;
    assign o_out.data_available  = r_avail;
    assign o_out.packet_complete = r_done;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the PS/2 mouse packet framer with byte FIFO.
// Depends on ps2mf_pkg, ps2mf_if and ps2_mouse_packet_framer_fifo; a local
// framer/FIFO predictor checks every result transfer in order.
module tb_top;

    // Command codes on the input channel
    localparam logic CMD_RX   = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 32;

    typedef struct packed {
        logic [7:0] read_data;
        logic       data_available;
        logic       packet_complete;
    } t_report;

    logic i_clk;
    logic i_rst_n;

    ps2mf_in_if  in_ch();
    ps2mf_out_if out_ch();

    ps2_mouse_packet_framer_fifo dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predictor state: byte FIFO and the packet being gathered
    logic [7:0]                    mouse_fifo [ps2mf_pkg::FIFO_DEPTH];
    logic [ps2mf_pkg::FIFO_AW-1:0] rd_ptr;
    logic [ps2mf_pkg::FIFO_AW-1:0] wr_ptr;
    int                            fifo_fill;
    logic [7:0]                    head_byte;
    logic [7:0]                    dx_byte;
    logic [1:0]                    gathered;

    t_report pending_reports[$];

    int  mismatches;
    int  items_sent;
    int  packets_framed;
    int  bytes_dropped;
    int  bytes_popped;
    int  reads_refused;
    bit  idle_on;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Push one byte; dropped when the FIFO is full
    function automatic void fifo_store_byte(logic [7:0] b);
        if (fifo_fill < ps2mf_pkg::FIFO_DEPTH) begin
            mouse_fifo[wr_ptr] = b;
            wr_ptr = wr_ptr + 1'b1;
            fifo_fill++;
        end else begin
            bytes_dropped++;
        end
    endfunction

    // One step of the framer: update state, return the expected result
    function automatic t_report framer_step(logic cmd, logic [7:0] rx, logic [7:0] minor);
        t_report r;
        r = '0;
        if (cmd == CMD_RX) begin
            case (gathered)
                ps2mf_pkg::GATHER_NONE: begin
                    // resync: first byte must carry the mark bit
                    if ((rx & ps2mf_pkg::FIRST_BYTE_MARK) != 8'h00) begin
                        head_byte = rx;
                        gathered  = ps2mf_pkg::GATHER_ONE;
                    end
                end
                ps2mf_pkg::GATHER_ONE: begin
                    dx_byte  = rx;
                    gathered = ps2mf_pkg::GATHER_TWO;
                end
                default: begin
                    fifo_store_byte(head_byte);
                    fifo_store_byte(dx_byte);
                    fifo_store_byte(rx);
                    gathered = ps2mf_pkg::GATHER_NONE;
                    r.packet_complete = 1'b1;
                    packets_framed++;
                end
            endcase
        end else if (minor != 8'h00) begin
            reads_refused++;
        end else if (fifo_fill > 0) begin
            r.read_data = mouse_fifo[rd_ptr];
            rd_ptr = rd_ptr + 1'b1;
            fifo_fill--;
            bytes_popped++;
        end
        r.data_available = (fifo_fill > 0);
        return r;
    endfunction

    // Input transfers feed the predictor; result transfers are checked in order
    always @(posedge i_clk) begin
        t_report exp_r;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                pending_reports.push_back(framer_step(in_ch.cmd, in_ch.rx_byte,
                                                      in_ch.minor_number));
            if (out_ch.valid && out_ch.ready) begin
                if (pending_reports.size() == 0) begin
                    $error("unexpected result transfer: read_data %0h", out_ch.read_data);
                    mismatches++;
                end else begin
                    exp_r = pending_reports.pop_front();
                    if (out_ch.read_data !== exp_r.read_data) begin
                        $error("read_data: expected %0h, got %0h",
                               exp_r.read_data, out_ch.read_data);
                        mismatches++;
                    end
                    if (out_ch.data_available !== exp_r.data_available) begin
                        $error("data_available: expected %0b, got %0b",
                               exp_r.data_available, out_ch.data_available);
                        mismatches++;
                    end
                    if (out_ch.packet_complete !== exp_r.packet_complete) begin
                        $error("packet_complete: expected %0b, got %0b",
                               exp_r.packet_complete, out_ch.packet_complete);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Result-side backpressure in random bursts
    initial begin : result_backpressure
        int hold;
        hold = 0;
        out_ch.ready <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold == 0 && idle_on && $urandom_range(0, 9) == 0)
                hold = $urandom_range(1, 14);
            out_ch.ready <= (hold == 0);
            if (hold != 0) hold--;
            @(posedge i_clk);
        end
    end

    // Ends the run if nothing transfers for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Drive one input item and hold it until the transfer
    task automatic send_item(logic cmd, logic [7:0] rx, logic [7:0] minor);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.cmd          <= cmd;
        in_ch.rx_byte      <= rx;
        in_ch.minor_number <= minor;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic rx_byte_in(logic [7:0] b);
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        send_item(CMD_RX, b, junk);
    endtask

    task automatic host_read(logic [7:0] minor);
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        send_item(CMD_READ, junk, minor);
    endtask

    // Well-formed packet with random content; optional read between bytes
    task automatic send_packet(int mid_read_pct);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        rx_byte_in(b | ps2mf_pkg::FIRST_BYTE_MARK);
        if ($urandom_range(0, 99) < mid_read_pct) host_read(8'h00);
        b = 8'($urandom_range(0, 255));
        rx_byte_in(b);
        b = 8'($urandom_range(0, 255));
        rx_byte_in(b);
    endtask

    // Bad first bytes, read corners and reads between packet bytes
    task automatic test_directed();
        host_read(8'h00);                   // empty FIFO
        rx_byte_in(8'h00);                  // no mark bit: dropped
        rx_byte_in(8'hF7);                  // all bits but the mark
        rx_byte_in(8'hFF);
        rx_byte_in(8'h00);
        rx_byte_in(8'hAA);
        host_read(8'hFF);                   // nonzero minor refused
        host_read(8'h01);
        rx_byte_in(8'h08);
        host_read(8'h00);                   // pop while gathering
        rx_byte_in(8'h80);
        rx_byte_in(8'h7F);
        repeat (6) host_read(8'h00);        // drain past empty
        send_item(CMD_READ, 8'hFF, 8'h00);
        rx_byte_in(8'h0F);
        rx_byte_in(8'hFF);
        rx_byte_in(8'hFF);
        repeat (3) host_read(8'h00);
    endtask

    // Overfill so a packet lands partly and one is lost; drain to wrap pointers
    task automatic test_fifo_overflow();
        logic [7:0] m;
        repeat (ps2mf_pkg::FIFO_DEPTH / 3 + 2) send_packet(0);
        repeat (4) begin
            m = 8'($urandom_range(1, 255));
            host_read(m);
        end
        repeat (ps2mf_pkg::FIFO_DEPTH + 1) host_read(8'h00);
    endtask

    // Mostly packets and reads, with noise bytes and broken packets
    task automatic test_random_traffic(int n_items, int read_pct, bit with_idle);
        int         stop_at;
        int         pick;
        logic [7:0] b;
        idle_on = with_idle;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 99) < read_pct) begin
                if ($urandom_range(0, 99) < 85) begin
                    host_read(8'h00);
                end else begin
                    b = 8'($urandom_range(1, 255));
                    host_read(b);
                end
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    send_packet(10);
                end else if (pick < 95) begin
                    b = 8'($urandom_range(0, 255));
                    rx_byte_in(b);
                end else begin
                    // header plus one byte, then the next packet starts early
                    b = 8'($urandom_range(0, 255));
                    rx_byte_in(b | ps2mf_pkg::FIRST_BYTE_MARK);
                    b = 8'($urandom_range(0, 255));
                    rx_byte_in(b);
                end
            end
        end
    endtask

    initial begin
        mismatches     = 0;
        items_sent     = 0;
        packets_framed = 0;
        bytes_dropped  = 0;
        bytes_popped   = 0;
        reads_refused  = 0;
        idle_on        = 1'b1;
        rd_ptr         = '0;
        wr_ptr         = '0;
        fifo_fill      = 0;
        head_byte      = '0;
        dx_byte        = '0;
        gathered       = ps2mf_pkg::GATHER_NONE;

        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.cmd          <= CMD_RX;
        in_ch.rx_byte      <= 8'h00;
        in_ch.minor_number <= 8'h00;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fifo_overflow();
        test_random_traffic(350, 15, 1'b1);
        test_random_traffic(350, 80, 1'b1);
        test_random_traffic(300, 45, 1'b1);
        test_random_traffic(250, 45, 1'b0);

        in_ch.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d items: %0d packets framed, %0d bytes dropped on full FIFO,",
                 items_sent, packets_framed, bytes_dropped);
        $display("  %0d bytes read back, %0d reads refused for nonzero minor",
                 bytes_popped, reads_refused);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
